/* hdl/assert_macros.svh */
// Assertion macros used by the parser's request queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define PPM6_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);
// Checks that a consequent holds in the same cycle as its antecedent.
`define PPM6_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define PPM6_ASSERT(lbl, expr, msg)
`define PPM6_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

/* hdl/ppm6_pkg.sv */
// Shared types, codes and constants of the PPM P6 stream parser.
package ppm6_pkg;

	localparam int DIM_BITS_DEF    = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] MAXVAL_REQ = 8'd255;

	localparam logic [1:0] CHAN_BLUE = 2'd2;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_BAD_MAGIC   = 3'd0,
		ERR_BAD_WIDTH   = 3'd1,
		ERR_BAD_HEIGHT  = 3'd2,
		ERR_BAD_MAXVAL  = 3'd3,
		ERR_MAXVAL_255  = 3'd4,
		ERR_EARLY_END   = 3'd5,
		ERR_INCOMPLETE  = 3'd6
	} err_code_t;

	typedef enum logic [1:0] {
		CMD_DATA   = 2'd0,
		CMD_HEADER = 2'd1,
		CMD_ERROR  = 2'd2,
		CMD_EOF    = 2'd3
	} cmd_op_t;

	// One request from the header front end to the pixel back end.
	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  data_byte;
		err_code_t   code;
		logic [15:0] width;
		logic [15:0] height;
	} cmd_t;

	// One result as presented on the output stream.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  pixel;
		logic [1:0]  chan;
		logic        last;
		logic [2:0]  code;
	} res_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

/* hdl/ppm6_front.sv */
// Header tokenizer: classifies input bytes and issues requests to the back end.
module ppm6_front import ppm6_pkg::*; #(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  logic [7:0]              byte_in,
	input  logic                    eof_in,
	output logic                    push,
	output cmd_t                    cmd,
	output logic [2*DIM_BITS+1:0]   cmd_total
);

	localparam int CNT_BITS = 2 * DIM_BITS + 2;
	localparam int ACC_BITS = DIM_BITS + 1;
	localparam int MUL_BITS = DIM_BITS + 5;

	typedef enum logic [2:0] {
		PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_IDLE
	} phase_t;

	phase_t                phase_q, phase_d;
	logic                  in_comment_q, in_comment_d;
	logic                  in_token_q, in_token_d;
	logic [1:0]            tok_len_q, tok_len_d;
	logic                  tok_valid_q, tok_valid_d;
	logic                  tok_neg_q, tok_neg_d;
	logic [ACC_BITS-1:0]   acc_q, acc_d;
	logic [DIM_BITS-1:0]   width_q, width_d;
	logic [DIM_BITS-1:0]   height_q, height_d;
	logic [2*DIM_BITS-1:0] area_q;

	logic [MUL_BITS-1:0]   acc_ext;
	logic [MUL_BITS-1:0]   acc_next;
	logic                  is_digit;
	logic                  tok_bad;
	err_code_t             tok_code;
	logic [DIM_BITS+15:0]  width_ext;
	logic [DIM_BITS+15:0]  height_ext;

	assign acc_ext  = {4'b0, acc_q};
	assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign acc_next = (acc_ext << 3) + (acc_ext << 1)
		+ MUL_BITS'(4'(byte_in - CH_ZERO));
	assign width_ext  = {16'b0, width_q};
	assign height_ext = {16'b0, height_q};

	// Verdict on the token that is open now.
	always_comb begin
		tok_bad  = 1'b0;
		tok_code = ERR_BAD_MAGIC;
		if (phase_q == PH_MAGIC) begin
			tok_bad = !(tok_valid_q && (tok_len_q == 2'd2));
		end else begin
			case (phase_q)
				PH_WIDTH:  tok_code = ERR_BAD_WIDTH;
				PH_HEIGHT: tok_code = ERR_BAD_HEIGHT;
				default:   tok_code = ERR_BAD_MAXVAL;
			endcase
			if (!tok_valid_q || tok_neg_q || (acc_q == '0) || acc_q[DIM_BITS]) begin
				tok_bad = 1'b1;
			end else if ((phase_q == PH_MAXVAL) && (acc_q != ACC_BITS'(MAXVAL_REQ))) begin
				tok_bad  = 1'b1;
				tok_code = ERR_MAXVAL_255;
			end
		end
	end

	always_comb begin
		phase_d      = phase_q;
		in_comment_d = in_comment_q;
		in_token_d   = in_token_q;
		tok_len_d    = tok_len_q;
		tok_valid_d  = tok_valid_q;
		tok_neg_d    = tok_neg_q;
		acc_d        = acc_q;
		width_d      = width_q;
		height_d     = height_q;
		push         = 1'b0;
		cmd          = '0;
		cmd_total    = '0;

		if (item_valid) begin
			if (eof_in) begin
				if ((phase_q == PH_MAGIC) || (phase_q == PH_WIDTH) ||
						(phase_q == PH_HEIGHT) || (phase_q == PH_MAXVAL)) begin
					push    = 1'b1;
					cmd.op  = CMD_ERROR;
					if (!in_token_q)
						cmd.code = ERR_EARLY_END;
					else if (tok_bad)
						cmd.code = tok_code;
					else if (phase_q == PH_MAXVAL)
						cmd.code = ERR_INCOMPLETE;
					else
						cmd.code = ERR_EARLY_END;
				end else if (phase_q == PH_PIXELS) begin
					push   = 1'b1;
					cmd.op = CMD_EOF;
				end
				phase_d      = PH_MAGIC;
				in_comment_d = 1'b0;
				in_token_d   = 1'b0;
				tok_len_d    = '0;
				tok_valid_d  = 1'b1;
				tok_neg_d    = 1'b0;
				acc_d        = '0;
				width_d      = '0;
				height_d     = '0;
			end else if (phase_q == PH_PIXELS) begin
				push          = 1'b1;
				cmd.op        = CMD_DATA;
				cmd.data_byte = byte_in;
			end else if (phase_q == PH_IDLE) begin
				phase_d = PH_IDLE;
			end else if (in_comment_q) begin
				if (byte_in == CH_LF)
					in_comment_d = 1'b0;
			end else if (!in_token_q && is_space(byte_in)) begin
				in_token_d = 1'b0;
			end else if (!in_token_q && (byte_in == CH_HASH)) begin
				in_comment_d = 1'b1;
			end else if (!in_token_q || !is_space(byte_in)) begin
				// Token byte: a closed token holds its reset values, so the same
				// update serves the first byte and the ones after it.
				in_token_d = 1'b1;
				tok_len_d  = (tok_len_q == 2'd3) ? 2'd3 : tok_len_q + 2'd1;
				if (phase_q == PH_MAGIC) begin
					if (!(((tok_len_q == 2'd0) && (byte_in == CH_P)) ||
							((tok_len_q == 2'd1) && (byte_in == CH_SIX))))
						tok_valid_d = 1'b0;
				end else if ((tok_len_q == 2'd0) &&
						((byte_in == CH_PLUS) || (byte_in == CH_MINUS))) begin
					if (byte_in == CH_MINUS)
						tok_neg_d = 1'b1;
				end else if (is_digit) begin
					if (|acc_next[MUL_BITS-1:DIM_BITS])
						acc_d = {1'b1, {DIM_BITS{1'b0}}};
					else
						acc_d = acc_next[ACC_BITS-1:0];
				end else begin
					tok_valid_d = 1'b0;
				end
			end else begin
				// Whitespace closes the token.
				in_token_d  = 1'b0;
				tok_len_d   = '0;
				tok_valid_d = 1'b1;
				tok_neg_d   = 1'b0;
				acc_d       = '0;
				if (tok_bad) begin
					push     = 1'b1;
					cmd.op   = CMD_ERROR;
					cmd.code = tok_code;
					phase_d  = PH_IDLE;
				end else begin
					case (phase_q)
						PH_MAGIC: phase_d = PH_WIDTH;
						PH_WIDTH: begin
							width_d = acc_q[DIM_BITS-1:0];
							phase_d = PH_HEIGHT;
						end
						PH_HEIGHT: begin
							height_d = acc_q[DIM_BITS-1:0];
							phase_d  = PH_MAXVAL;
						end
						default: begin
							push       = 1'b1;
							cmd.op     = CMD_HEADER;
							cmd.width  = width_ext[15:0];
							cmd.height = height_ext[15:0];
							cmd_total  = {area_q, 1'b0} + CNT_BITS'(area_q);
							phase_d    = PH_PIXELS;
						end
					endcase
				end
			end
		end
	end

	// The area is registered in the cycle after the height is stored; the maxval
	// token needs at least two more bytes, so the header always sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MAGIC;
			in_comment_q <= 1'b0;
			in_token_q   <= 1'b0;
			tok_len_q    <= '0;
			tok_valid_q  <= 1'b1;
			tok_neg_q    <= 1'b0;
			acc_q        <= '0;
			width_q      <= '0;
			height_q     <= '0;
			area_q       <= '0;
		end else begin
			phase_q      <= phase_d;
			in_comment_q <= in_comment_d;
			in_token_q   <= in_token_d;
			tok_len_q    <= tok_len_d;
			tok_valid_q  <= tok_valid_d;
			tok_neg_q    <= tok_neg_d;
			acc_q        <= acc_d;
			width_q      <= width_d;
			height_q     <= height_d;
			area_q       <= width_q * height_q;
		end
	end

endmodule

/* hdl/ppm6_queue.sv */
// Small request queue between the front end and the back end.
`include "assert_macros.svh"
module ppm6_queue import ppm6_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	`PPM6_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count exceeds depth")
	`PPM6_ASSERT_IMPL(a_no_overflow, full, !push, "request pushed into a full queue")
	`PPM6_ASSERT_IMPL(a_no_underflow, empty, !pop, "request popped from an empty queue")

endmodule

/* hdl/ppm6_back.sv */
// Pixel back end: counts pixel bytes, tags channels and holds the output result.
module ppm6_back import ppm6_pkg::*; #(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_empty,
	input  cmd_t                  cmd,
	input  logic [2*DIM_BITS+1:0] cmd_total,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res
);

	localparam int CNT_BITS = 2 * DIM_BITS + 2;

	logic [CNT_BITS-1:0] remaining_q, remaining_d;
	logic [1:0]          chan_q, chan_d;
	logic                out_valid_q;
	res_t                out_q;
	logic                produce;
	res_t                res_d;

	assign pop       = !cmd_empty && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		remaining_d = remaining_q;
		chan_d      = chan_q;
		produce     = 1'b0;
		res_d       = '0;
		res_d.kind  = KIND_ERROR;
		case (cmd.op)
			CMD_HEADER: begin
				produce      = 1'b1;
				res_d.kind   = KIND_HEADER;
				res_d.width  = cmd.width;
				res_d.height = cmd.height;
				remaining_d  = cmd_total;
				chan_d       = '0;
			end
			CMD_DATA: begin
				// Bytes past the end of the image are dropped.
				if (remaining_q != '0) begin
					produce     = 1'b1;
					res_d.kind  = KIND_PIXEL;
					res_d.pixel = cmd.data_byte;
					res_d.chan  = chan_q;
					res_d.last  = (remaining_q == CNT_BITS'(1));
					remaining_d = remaining_q - CNT_BITS'(1);
					chan_d      = (chan_q == CHAN_BLUE) ? 2'd0 : chan_q + 2'd1;
				end
			end
			CMD_ERROR: begin
				produce     = 1'b1;
				res_d.code  = cmd.code;
				remaining_d = '0;
				chan_d      = '0;
			end
			CMD_EOF: begin
				produce     = (remaining_q != '0);
				res_d.code  = ERR_INCOMPLETE;
				remaining_d = '0;
				chan_d      = '0;
			end
			default: begin
				produce = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			chan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				remaining_q <= remaining_d;
				chan_q      <= chan_d;
				out_valid_q <= produce;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && produce)
			out_q <= res_d;
	end

endmodule

/* hdl/ppm6_stream_parser_top.sv */
// Top level of the PPM P6 stream parser.
// ppm_p6_stream_parser takes a P6 file one byte per request: each byte is
// classified by the header front end in the cycle it arrives and the resulting
// request is carried out by the pixel back end, with a four-entry queue between
// them; a result is registered in the queue and then in the back end's output
// register before it is valid on the output stream. The header ends on the
// single whitespace byte after maxval; a header result carries width and
// height, then width*height*3 pixel results follow, each with its color
// channel and the last one marked. The pixel count comes from one DIM_BITS
// by DIM_BITS multiplier whose product is registered while the maxval token
// is being read. The first error ends the image; a request with tlast set
// closes the file and rearms the parser. Input backpressure appears only when
// the queue fills under a stalled output.
module ppm_p6_stream_parser import ppm6_pkg::*; #(
	parameter int DIM_BITS    = DIM_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // end_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] image_width, [31:16] image_height,
	                               // [39:32] pixel_byte, [41:40] color_channel,
	                               // [44:42] error_code, [47:45] zero
	output logic        m_tlast,   // last_pixel
	output logic [1:0]  m_tuser    // result_kind
);

	localparam int CNT_BITS = 2 * DIM_BITS + 2;
	localparam int Q_WIDTH  = $bits(cmd_t) + CNT_BITS;

	logic                accept;
	logic                push;
	cmd_t                front_cmd;
	logic [CNT_BITS-1:0] front_total;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;
	logic [Q_WIDTH-1:0]  q_rd;
	cmd_t                back_cmd;
	logic [CNT_BITS-1:0] back_total;
	res_t                res;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	ppm6_front #(
		.DIM_BITS(DIM_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(accept),
		.byte_in   (s_tdata),
		.eof_in    (s_tlast),
		.push      (push),
		.cmd       (front_cmd),
		.cmd_total (front_total)
	);

	ppm6_queue #(
		.WIDTH(Q_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data({front_total, front_cmd}),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rd_data(q_rd)
	);

	assign back_cmd   = cmd_t'(q_rd[$bits(cmd_t)-1:0]);
	assign back_total = q_rd[Q_WIDTH-1:$bits(cmd_t)];

	ppm6_back #(
		.DIM_BITS(DIM_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(q_empty),
		.cmd      (back_cmd),
		.cmd_total(back_total),
		.pop      (q_pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tdata = {3'b000, res.code, res.chan, res.pixel, res.height, res.width};
	assign m_tlast = res.last;
	assign m_tuser = res.kind;

endmodule
